>>> src/prw_pkg.sv
// ----------------------------------------------------------------------------
// prw_pkg
// Shared types and constants for the row-gradient edge filter.
// ----------------------------------------------------------------------------
package prw_pkg;

   localparam int PIXEL_W = 8;
   localparam int SUM_W   = 10;   // three pixels summed
   localparam int GRAD_W  = 11;
   localparam int POS_W   = 11;
   localparam int CFG_W   = 12;
   localparam int CSR_IDX_W = 1;

   localparam int ROWS_RESET = 480;
   localparam int COLS_RESET = 640;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'b1;

   // one line buffer entry: row two above and row just above
   typedef struct packed {
      logic [PIXEL_W-1:0] older;
      logic [PIXEL_W-1:0] previous;
   } line_pair_type;

   typedef struct packed {
      logic interior;
      logic frame_last;
   } pos_flags_type;

endpackage

>>> src/prewitt_row_gradient_3x3_top.sv
// ----------------------------------------------------------------------------
// prewitt_row_gradient_3x3_top
// Row-gradient edge filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order, unless a result waits on
// a full result register, and, for every interior pixel, returns the sum of
// the three pixels in the row above minus the sum of the three in the row
// below, with the centre row/column and a flag on the last interior result
// of the frame. Border pixels return nothing. A request sits in an input
// stage while the line buffer is read, and its result is then registered;
// the rate is set by the line buffer's single read and single write port
// per cycle. Frame size is written through the CSR port while idle; sizes
// below 3 act as 3 and sizes above the maximum act as the maximum.
module prewitt_row_gradient_3x3_top #(
   parameter int MAX_COLS = 2048,
   parameter int MAX_ROWS = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [prw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [prw_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [prw_pkg::PIXEL_W-1:0]        req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [prw_pkg::GRAD_W-1:0]  rsp_gradient,
   output logic [prw_pkg::POS_W-1:0]          rsp_out_row,
   output logic [prw_pkg::POS_W-1:0]          rsp_out_col,
   output logic                               rsp_frame_last
);
   import prw_pkg::*;

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_COLS);
   localparam int RSW = RW + 1;
   localparam int CSW = CW + 1;
   localparam int ROWS_RST = (MAX_ROWS < ROWS_RESET) ? MAX_ROWS : ROWS_RESET;
   localparam int COLS_RST = (MAX_COLS < COLS_RESET) ? MAX_COLS : COLS_RESET;

   // ---------------- configuration, stored already clamped ----------------
   logic [RSW-1:0] rows_ff, rows_in;
   logic [CSW-1:0] cols_ff, cols_in;
   logic           csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr && csr_index == CSR_NUM_ROWS) begin
         if (csr_wdata < CFG_W'(3)) begin
            rows_in = RSW'(3);
         end else if (32'(csr_wdata) > MAX_ROWS) begin
            rows_in = RSW'(MAX_ROWS);
         end else begin
            rows_in = RSW'(csr_wdata);
         end
      end
      if (csr_wr && csr_index == CSR_NUM_COLS) begin
         if (csr_wdata < CFG_W'(3)) begin
            cols_in = CSW'(3);
         end else if (32'(csr_wdata) > MAX_COLS) begin
            cols_in = CSW'(MAX_COLS);
         end else begin
            cols_in = CSW'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RSW'(ROWS_RST);
         cols_ff <= CSW'(COLS_RST);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // ---------------- position tracking ----------------
   logic          req_acc;
   logic          a_adv;
   logic [RW-1:0] pos_row;
   logic [CW-1:0] pos_col;
   pos_flags_type pos_flags;

   assign req_acc = req_valid && req_ready;

   prw_pos #(
      .RW (RW),
      .CW (CW)
   ) u_pos (
      .clock   (clock),
      .reset   (reset),
      .advance (req_acc),
      .rows    (rows_ff),
      .cols    (cols_ff),
      .row     (pos_row),
      .col     (pos_col),
      .flags   (pos_flags)
   );

   // ---------------- input stage (line buffer read in flight) ----------------
   logic               a_vld_ff, a_vld_in;
   logic [PIXEL_W-1:0] a_px_ff;
   logic [RW-1:0]      a_row_ff;
   logic [CW-1:0]      a_col_ff;
   pos_flags_type      a_flags_ff;
   line_pair_type      lb_rd;
   line_pair_type      lb_wr;

   prw_linebuf #(
      .DEPTH (MAX_COLS),
      .AW    (CW)
   ) u_linebuf (
      .clock      (clock),
      .rd_en      (req_acc),
      .rd_addr    (pos_col),
      .wr_en      (a_adv),
      .wr_addr    (a_col_ff),
      .wr_data    (lb_wr),
      .rd_data_ff (lb_rd)
   );

   // an item with no result retires even when the output register is full
   assign a_adv     = a_vld_ff && (!a_flags_ff.interior || !rsp_valid || rsp_ready);
   assign req_ready = !a_vld_ff || a_adv;
   assign a_vld_in  = req_acc ? 1'b1 : (a_adv ? 1'b0 : a_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_px_ff    <= req_pixel;
         a_row_ff   <= pos_row;
         a_col_ff   <= pos_col;
         a_flags_ff <= pos_flags;
      end
   end

   assign lb_wr.older    = lb_rd.previous;
   assign lb_wr.previous = a_px_ff;

   // ---------------- window registers ----------------
   logic [PIXEL_W-1:0] uw0_ff, uw1_ff, lw0_ff, lw1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         uw0_ff <= '0;
         uw1_ff <= '0;
         lw0_ff <= '0;
         lw1_ff <= '0;
      end else if (a_adv) begin
         uw1_ff <= uw0_ff;
         uw0_ff <= lb_rd.older;
         lw1_ff <= lw0_ff;
         lw0_ff <= a_px_ff;
      end
   end

   // ---------------- gradient and result register ----------------
   logic [SUM_W-1:0]  upper_sum, lower_sum;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GRAD_W-1:0] grad_ff, grad_in;
   logic [POS_W-1:0]  out_row_ff, out_row_in;
   logic [POS_W-1:0]  out_col_ff, out_col_in;
   logic              last_ff;
   logic              load_rsp;

   always_comb begin
      upper_sum  = SUM_W'(uw0_ff) + SUM_W'(uw1_ff) + SUM_W'(lb_rd.older);
      lower_sum  = SUM_W'(lw0_ff) + SUM_W'(lw1_ff) + SUM_W'(a_px_ff);
      grad_in    = GRAD_W'(upper_sum) - GRAD_W'(lower_sum);
      out_row_in = POS_W'({{POS_W{1'b0}}, a_row_ff} - 1'b1);
      out_col_in = POS_W'({{POS_W{1'b0}}, a_col_ff} - 1'b1);
   end

   assign load_rsp     = a_adv && a_flags_ff.interior;
   assign rsp_valid_in = load_rsp ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         grad_ff    <= grad_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         last_ff    <= a_flags_ff.frame_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gradient   = $signed(grad_ff);
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_frame_last = last_ff;

`ifndef SYNTHESIS
   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // line buffer read and write in the same cycle never hit the same entry
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (req_acc && a_adv) |-> (pos_col != a_col_ff))
      else $error("line buffer read/write collision");

   // every result comes from an interior window
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_row != '0 && rsp_out_col != '0))
      else $error("border position in result");

   // an accepted request occupies the input stage on the next cycle
   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> a_vld_ff)
      else $error("accepted request lost");
`endif

endmodule

>>> src/prw_linebuf.sv
// ----------------------------------------------------------------------------
// prw_linebuf
// Paired line buffer memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prw_linebuf #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  prw_pkg::line_pair_type wr_data,
   output prw_pkg::line_pair_type rd_data_ff
);
   import prw_pkg::*;

   line_pair_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> src/prw_pos.sv
// ----------------------------------------------------------------------------
// prw_pos
// Raster position tracker: row/column of the incoming pixel and its flags.
// ----------------------------------------------------------------------------
module prw_pos #(
   parameter int RW = 11,
   parameter int CW = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [RW:0]            rows,
   input  logic [CW:0]            cols,
   output logic [RW-1:0]          row,
   output logic [CW-1:0]          col,
   output prw_pkg::pos_flags_type flags
);
   import prw_pkg::*;

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW:0]   row_tmp;
   logic [RW:0]   row_nxt;
   logic [CW:0]   col_nxt;

   // position of this pixel; a shrunk size takes effect here
   always_comb begin
      if ({1'b0, col_ff} >= cols) begin
         col     = '0;
         row_tmp = {1'b0, row_ff} + 1'b1;
      end else begin
         col     = col_ff;
         row_tmp = {1'b0, row_ff};
      end
      if (row_tmp >= rows) begin
         row = '0;
      end else begin
         row = row_tmp[RW-1:0];
      end
   end

   always_comb begin
      flags.interior   = (row >= RW'(2)) && (col >= CW'(2));
      flags.frame_last = ({1'b0, row} == rows - 1'b1) && ({1'b0, col} == cols - 1'b1);
   end

   always_comb begin
      col_nxt = {1'b0, col} + 1'b1;
      row_nxt = {1'b0, row} + 1'b1;
      row_in  = row;
      col_in  = col_nxt[CW-1:0];
      if (col_nxt >= cols) begin
         col_in = '0;
         if (row_nxt >= rows) begin
            row_in = '0;
         end else begin
            row_in = row_nxt[RW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule
